[rtl/gsbf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbf_pkg
// Shared types and codes for the gshare predictor with target buffer filter.
// ----------------------------------------------------------------------------
package gsbf_pkg;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  localparam logic [1:0] KIND_COND   = 2'd0;
  localparam logic [1:0] KIND_DIRECT = 2'd1;
  localparam logic [1:0] KIND_CALL   = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  // target buffer geometry, sets per buffer must be a power of two
  localparam int BUFFER_ENTRIES = 64;
  localparam int BUFFER_WAYS    = 4;

  // controller to datapath
  typedef struct packed {
    logic capture;    // register the input item
    logic read_mem;   // issue counter and buffer set reads
    logic evaluate;   // form the result and write back state
    logic age;        // increment all rereference values of the set
    logic clear;      // write one counter entry to its reset value
  } gsbf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_update;
    logic need_age;   // insert pending with no invalid way and no way at max
    logic clear_last; // clearing pass is at its last entry
  } gsbf_sts_t;

endpackage

[rtl/gsbf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbf_ctrl
// Sequencer: clearing pass, then capture, read, evaluate (with aging loop) and, for a predict, result hold.
// ----------------------------------------------------------------------------
module gsbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gsbf_pkg::gsbf_sts_t sts,
  output gsbf_pkg::gsbf_cmd_t cmd
);
  import gsbf_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_AGE   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_mem = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.need_age) begin
          state_nxt = ST_AGE;
        end else begin
          cmd.evaluate = 1'b1;
          state_nxt = sts.is_update ? ST_IDLE : ST_OUT;
        end
      end
      ST_AGE: begin
        cmd.age = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

`ifndef SYNTH
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");
`endif

endmodule

[rtl/gsbf_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbf_datapath
// Counter memory, target buffer tags, valid bits and replacement values.
// ----------------------------------------------------------------------------
module gsbf_datapath #(
  parameter int HISTORY_BITS   = 12,
  parameter int COUNTER_BITS   = 2,
  parameter int RRPV_BITS      = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gsbf_pkg::gsbf_cmd_t cmd,
  output gsbf_pkg::gsbf_sts_t sts,
  input  logic              in_operation,
  input  logic [63:0]       in_pc,
  input  logic [1:0]        in_branch_kind,
  input  logic [63:0]       in_history_address,
  input  logic [31:0]       in_global_history,
  input  logic              in_taken,
  output logic              out_predict_taken,
  output logic              out_buffer_hit
);
  import gsbf_pkg::*;

  localparam int SETS_RAW = BUFFER_ENTRIES / BUFFER_WAYS;
  localparam int SETS     = (SETS_RAW > 0) ? SETS_RAW : 1;
  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_SH   = $clog2(SETS);
  localparam int TAG_BITS = 64 - SET_SH;
  localparam int TBL      = 1 << HISTORY_BITS;
  localparam logic [COUNTER_BITS-1:0] CTR_MAX  = '1;
  localparam logic [COUNTER_BITS-1:0] CTR_INIT = COUNTER_BITS'(1 << (COUNTER_BITS - 1));
  localparam logic [RRPV_BITS-1:0]    RR_MAX   = '1;
  localparam int WAY_BITS = (BUFFER_WAYS > 1) ? $clog2(BUFFER_WAYS) : 1;

  // captured item
  logic                    op_r, taken_r;
  logic [1:0]              kind_r;
  logic [TAG_BITS-1:0]     tag_r;
  logic [SET_BITS-1:0]     set_r;
  logic [HISTORY_BITS-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      taken_r <= in_taken;
      kind_r  <= in_branch_kind;
      tag_r   <= in_pc[63 -: TAG_BITS];
      set_r   <= (SETS > 1) ? SET_BITS'(in_pc[SET_BITS-1:0]) : '0;
      idx_r   <= in_global_history[31 -: HISTORY_BITS]
                 ^ in_history_address[HISTORY_BITS+1:2];
    end
  end

  // counter memory with clearing pass
  logic [COUNTER_BITS-1:0] ctr_mem [TBL];
  logic [COUNTER_BITS-1:0] ctr_rd_r;
  logic [HISTORY_BITS-1:0] clr_r;
  logic                    ctr_we;
  logic [HISTORY_BITS-1:0] ctr_wa;
  logic [COUNTER_BITS-1:0] ctr_wd, ctr_upd;

  always_comb begin
    ctr_upd = ctr_rd_r;
    if (taken_r) begin
      if (ctr_rd_r != CTR_MAX) ctr_upd = ctr_rd_r + 1'b1;
    end else begin
      if (ctr_rd_r != '0) ctr_upd = ctr_rd_r - 1'b1;
    end
  end

  assign ctr_we = cmd.clear
                  || (cmd.evaluate && op_r == OP_UPDATE && kind_r == KIND_COND);
  assign ctr_wa = cmd.clear ? clr_r : idx_r;
  assign ctr_wd = cmd.clear ? CTR_INIT : ctr_upd;

  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
    if (cmd.read_mem) ctr_rd_r <= ctr_mem[idx_r];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear) clr_r <= clr_r + 1'b1;
  end
  assign sts.clear_last = (clr_r == '1);

  // buffer tag memory, one row per set
  logic [TAG_BITS-1:0] tag_mem [SETS][BUFFER_WAYS];
  logic [TAG_BITS-1:0] tag_rd_r [BUFFER_WAYS];
  logic [BUFFER_WAYS-1:0] vld_r [SETS];
  logic [RRPV_BITS-1:0]   rr_r  [SETS][BUFFER_WAYS];

  // way compare and victim choice
  logic [BUFFER_WAYS-1:0] hit_v, inv_v, max_v;
  logic                   hit;
  logic [WAY_BITS-1:0]    hit_w, vic_w;
  logic                   have_inv, have_max;

  always_comb begin
    hit_w = '0; vic_w = '0; have_inv = 1'b0; have_max = 1'b0;
    for (int w = 0; w < BUFFER_WAYS; w++) begin
      hit_v[w] = vld_r[set_r][w] && (tag_rd_r[w] == tag_r);
      inv_v[w] = !vld_r[set_r][w];
      max_v[w] = (rr_r[set_r][w] == RR_MAX);
    end
    for (int w = BUFFER_WAYS - 1; w >= 0; w--) begin
      if (hit_v[w]) hit_w = WAY_BITS'(w);
      if (max_v[w]) begin vic_w = WAY_BITS'(w); have_max = 1'b1; end
    end
    for (int w = BUFFER_WAYS - 1; w >= 0; w--) begin
      if (inv_v[w]) begin vic_w = WAY_BITS'(w); have_inv = 1'b1; end
    end
    hit = |hit_v;
  end

  logic do_access;
  assign do_access = op_r == OP_UPDATE && kind_r != KIND_OTHER;
  assign sts.need_age  = do_access && !hit && !have_inv && !have_max;
  assign sts.is_update = (op_r == OP_UPDATE);

  always_ff @(posedge clk) begin
    if (cmd.read_mem) begin
      for (int w = 0; w < BUFFER_WAYS; w++) tag_rd_r[w] <= tag_mem[set_r][w];
    end
    if (cmd.evaluate && do_access && !hit) tag_mem[set_r][vic_w] <= tag_r;
  end

  // valid bits and replacement values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        vld_r[s] <= '0;
        for (int w = 0; w < BUFFER_WAYS; w++) rr_r[s][w] <= RR_MAX;
      end
    end else if (cmd.age) begin
      for (int w = 0; w < BUFFER_WAYS; w++) rr_r[set_r][w] <= rr_r[set_r][w] + 1'b1;
    end else if (cmd.evaluate && do_access) begin
      if (hit) begin
        rr_r[set_r][hit_w] <= '0;
      end else begin
        vld_r[set_r][vic_w] <= 1'b1;
        rr_r[set_r][vic_w]  <= RR_MAX - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.evaluate && op_r == OP_PREDICT) begin
      out_buffer_hit    <= hit;
      out_predict_taken <= hit && ((kind_r != KIND_COND) || ctr_rd_r[COUNTER_BITS-1]);
    end
  end

`ifndef SYNTH
  a_no_age_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.age |-> !hit) else $error("aging on a hit");
  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !cmd.evaluate && !cmd.capture) else $error("clear overlaps item");
  a_age_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.age |=> !cmd.age) else $error("aging twice in a row");
`endif

endmodule

[rtl/gshare_predictor_with_btb_filter_top.sv]
`timescale 1ns / 1ps
// result: a predict item's result is registered in the evaluate state, after the read state
// sequence: idle, read, evaluate, and for a predict the output state until taken; no new item is
//   taken before the last is through; up to 2^RRPV_BITS-1 aging steps on an insert into a full set
// reset: counter memory cleared by a pass over all 2^HISTORY_BITS entries, one entry per cycle,
//   during which no item is accepted; valid bits and replacement values clear at once
// ----------------------------------------------------------------------------
// gshare_predictor_with_btb_filter_top
// Gshare direction predictor filtered by a tag-only set-associative buffer.
// ----------------------------------------------------------------------------
module gshare_predictor_with_btb_filter_top #(
  parameter int HISTORY_BITS   = 12,
  parameter int COUNTER_BITS   = 2,
  parameter int RRPV_BITS      = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [63:0] in_pc,
  input  logic [1:0]  in_branch_kind,
  input  logic [63:0] in_history_address,
  input  logic [31:0] in_global_history,
  input  logic        in_taken,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_predict_taken,
  output logic        out_buffer_hit
);
  import gsbf_pkg::*;

  gsbf_cmd_t cmd;
  gsbf_sts_t sts;

  gsbf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  gsbf_datapath #(
    .HISTORY_BITS(HISTORY_BITS), .COUNTER_BITS(COUNTER_BITS),
    .RRPV_BITS(RRPV_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_operation, .in_pc, .in_branch_kind, .in_history_address,
    .in_global_history, .in_taken, .out_predict_taken, .out_buffer_hit
  );

endmodule
